FILE: sv/itp_pkg.sv
package itp_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned IdWidth    = 11;
  localparam int unsigned LenWidth   = 12;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned FrameBytes = 8;
  localparam int unsigned FrameWidth = FrameBytes * ByteWidth;
  localparam int unsigned PosWidth   = $clog2(FrameBytes);
  localparam int unsigned SeqWidth   = 4;

  // Configuration port layout.
  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;
  localparam logic        RegPadding   = 1'b0;

  // Protocol control nibbles and reset values.
  localparam logic [3:0]          PciFirstFrame  = 4'h1;
  localparam logic [3:0]          PciConsecutive = 4'h2;
  localparam logic [ByteWidth-1:0] PadReset      = 8'hAA;
  localparam logic [SeqWidth-1:0] SeqStart       = 4'd1;
  localparam logic [PosWidth-1:0] PosLast        = 3'd7;
  localparam logic [LenWidth-1:0] SingleLimit    = 12'd8;

  // One emitted CAN frame.
  typedef struct packed {
    logic [IdWidth-1:0]    id;
    logic [FrameWidth-1:0] data;
    logic                  last;
  } itp_frame_t;

  // Replace byte pos of a frame word; byte 0 sits in the top bits.
  function automatic logic [FrameWidth-1:0] put_byte(
    input logic [FrameWidth-1:0] word,
    input logic [PosWidth-1:0]   pos,
    input logic [ByteWidth-1:0]  b
  );
    logic [FrameWidth-1:0] res;
    logic [5:0]            sh;
    res = word;
    sh  = {~pos, 3'b000};
    res[sh +: ByteWidth] = b;
    return res;
  endfunction

endpackage

FILE: sv/itp_apb_regs.sv
module itp_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [itp_pkg::ApbAddrWidth-1:0]   paddr,
  input  logic [itp_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [itp_pkg::ApbDataWidth-1:0]   prdata,
  output logic                               pready,
  output logic [itp_pkg::ByteWidth-1:0]      padding_o
);

  logic [itp_pkg::ByteWidth-1:0] padding_q;
  logic                          sel_padding;
  logic                          wr_en;

  // Word index decode; only the padding register exists.
  assign sel_padding = (paddr[2] == itp_pkg::RegPadding);
  assign wr_en       = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      padding_q <= itp_pkg::PadReset;
    end else if (wr_en && sel_padding) begin
      padding_q <= pwdata[itp_pkg::ByteWidth-1:0];
    end
  end

  // Reads return the register or zero for unmapped words.
  always_comb begin
    prdata = '0;
    if (sel_padding) begin
      prdata[itp_pkg::ByteWidth-1:0] = padding_q;
    end
  end

  assign pready    = 1'b1;
  assign padding_o = padding_q;

endmodule

FILE: sv/itp_frame_builder.sv
module itp_frame_builder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [itp_pkg::IdWidth-1:0]     can_id_i,
  input  logic [itp_pkg::LenWidth-1:0]    message_length_i,
  input  logic [itp_pkg::ByteWidth-1:0]   data_byte_i,
  input  logic [itp_pkg::ByteWidth-1:0]   padding_i,
  output logic                            emit_o,
  output itp_pkg::itp_frame_t             frame_o
);

  logic                              in_msg_q, in_msg_d;
  logic [itp_pkg::IdWidth-1:0]       id_q, id_d;
  logic [itp_pkg::LenWidth-1:0]      len_q, len_d;
  logic [itp_pkg::LenWidth-1:0]      taken_q, taken_d;
  logic [itp_pkg::FrameWidth-1:0]    buf_q, buf_d;
  logic [itp_pkg::PosWidth-1:0]      fill_q, fill_d;
  logic [itp_pkg::SeqWidth-1:0]      seq_q, seq_d;

  logic [itp_pkg::FrameWidth-1:0]    pad_word;
  logic [itp_pkg::PosWidth-1:0]      pos;
  logic                              done;

  assign pad_word = {itp_pkg::FrameBytes{padding_i}};

  // One byte step: open a frame if needed, insert the byte (none for an empty message), close on full or done.
  always_comb begin
    in_msg_d = in_msg_q;
    id_d     = id_q;
    len_d    = len_q;
    taken_d  = taken_q;
    buf_d    = buf_q;
    fill_d   = fill_q;
    seq_d    = seq_q;
    pos      = fill_q;
    done     = 1'b0;
    emit_o   = 1'b0;
    frame_o.last = 1'b0;

    if (!in_msg_q) begin
      // New message: latch identifier and length, open the first frame.
      id_d    = can_id_i;
      len_d   = message_length_i;
      taken_d = '0;
      seq_d   = itp_pkg::SeqStart;
      buf_d   = pad_word;
      if (message_length_i == '0) begin
        buf_d  = itp_pkg::put_byte(pad_word, '0, '0);
        pos    = '0;
        emit_o = 1'b1;
        frame_o.last = 1'b1;
      end else if (message_length_i < itp_pkg::SingleLimit) begin
        buf_d = itp_pkg::put_byte(buf_d, 3'd0, message_length_i[7:0]);
        pos   = 3'd1;
      end else begin
        buf_d = itp_pkg::put_byte(buf_d, 3'd0,
                                  {itp_pkg::PciFirstFrame, message_length_i[11:8]});
        buf_d = itp_pkg::put_byte(buf_d, 3'd1, message_length_i[7:0]);
        pos   = 3'd2;
      end
    end else if (fill_q == '0) begin
      // Open a consecutive frame.
      buf_d = itp_pkg::put_byte(pad_word, 3'd0, {itp_pkg::PciConsecutive, seq_q});
      seq_d = seq_q + 1'b1;
      pos   = 3'd1;
    end

    // Insert the byte unless the message was empty.
    if (in_msg_q || (message_length_i != '0)) begin
      buf_d   = itp_pkg::put_byte(buf_d, pos, data_byte_i);
      taken_d = taken_q + 1'b1;
      if (!in_msg_q) begin
        taken_d = {{(itp_pkg::LenWidth-1){1'b0}}, 1'b1};
      end
      done = (taken_d == len_d);
      if ((pos == itp_pkg::PosLast) || done) begin
        emit_o       = 1'b1;
        frame_o.last = done;
        fill_d       = '0;
        in_msg_d     = !done;
      end else begin
        fill_d   = pos + 1'b1;
        in_msg_d = 1'b1;
      end
    end else begin
      fill_d   = '0;
      in_msg_d = 1'b0;
    end

    frame_o.id   = id_d;
    frame_o.data = buf_d;
    emit_o       = emit_o && step_i;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      taken_q  <= '0;
      fill_q   <= '0;
      seq_q    <= itp_pkg::SeqStart;
    end else if (step_i) begin
      in_msg_q <= in_msg_d;
      taken_q  <= taken_d;
      fill_q   <= fill_d;
      seq_q    <= seq_d;
    end
  end

  // Message and frame payload.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      id_q  <= id_d;
      len_q <= len_d;
      buf_q <= buf_d;
    end
  end

endmodule

FILE: sv/isotp_transmit_segmenter.sv
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------------
// request   | in_valid_i / in_ready_o      | can_id_i, message_length_i, data_byte_i
// frame     | out_valid_o / out_ready_i    | frame_id_o, frame_data_o, last_of_message_o
// config    | psel, penable, pwrite/pready | paddr, pwdata, prdata (padding at 0x0)
//
// One request is taken per cycle while the output register is not held; the request
// that completes a frame passes the input register, then the builder into the output register.
// A full output register that is not taken holds the input register, which then
// holds in_ready_o low; no request is dropped.
// Reset clears the message state and sets the padding byte to 0xAA.
module isotp_transmit_segmenter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [itp_pkg::IdWidth-1:0]        can_id_i,
  input  logic [itp_pkg::LenWidth-1:0]       message_length_i,
  input  logic [itp_pkg::ByteWidth-1:0]      data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [itp_pkg::IdWidth-1:0]        frame_id_o,
  output logic [itp_pkg::FrameWidth-1:0]     frame_data_o,
  output logic                               last_of_message_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [itp_pkg::ApbAddrWidth-1:0]   paddr,
  input  logic [itp_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [itp_pkg::ApbDataWidth-1:0]   prdata,
  output logic                               pready
);

  logic                             s1_valid_q;
  logic [itp_pkg::IdWidth-1:0]      s1_id_q;
  logic [itp_pkg::LenWidth-1:0]     s1_len_q;
  logic [itp_pkg::ByteWidth-1:0]    s1_byte_q;
  logic                             advance;
  logic                             in_take;
  logic [itp_pkg::ByteWidth-1:0]    padding;
  logic                             emit;
  itp_pkg::itp_frame_t              frame;
  logic                             out_valid_q;
  itp_pkg::itp_frame_t              out_frame_q;

  // Configuration register.
  itp_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .padding_o (padding)
  );

  // The held request moves on whenever the output register is free or drains.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_id_q   <= can_id_i;
      s1_len_q  <= message_length_i;
      s1_byte_q <= data_byte_i;
    end
  end

  // Frame assembly and message state.
  itp_frame_builder u_builder (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .can_id_i         (s1_id_q),
    .message_length_i (s1_len_q),
    .data_byte_i      (s1_byte_q),
    .padding_i        (padding),
    .emit_o           (emit),
    .frame_o          (frame)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_frame_q <= frame;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_id_o        = out_frame_q.id;
  assign frame_data_o      = out_frame_q.data;
  assign last_of_message_o = out_frame_q.last;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import itp_pkg::*;

  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 8;

  // Segmentation predictor and the queue of frames that are still owed.
  class frame_board;
    logic [ByteWidth-1:0]  pad;
    bit                    busy;
    logic [IdWidth-1:0]    held_id;
    logic [LenWidth-1:0]   held_len;
    logic [LenWidth-1:0]   taken;
    logic [FrameWidth-1:0] frame_word;
    logic [PosWidth-1:0]   pos;
    logic [SeqWidth-1:0]   seq;
    itp_frame_t            frames_due[$];
    int unsigned           errors;
    int unsigned           requests;
    int unsigned           checked;
    int unsigned           singles;
    int unsigned           firsts;
    int unsigned           consecutives;

    function new();
      pad          = PadReset;
      busy         = 1'b0;
      held_id      = '0;
      held_len     = '0;
      taken        = '0;
      frame_word   = {FrameBytes{PadReset}};
      pos          = '0;
      seq          = SeqStart;
      errors       = 0;
      requests     = 0;
      checked      = 0;
      singles      = 0;
      firsts       = 0;
      consecutives = 0;
    endfunction

    function void set_padding(input logic [ByteWidth-1:0] value);
      pad = value;
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction

    // Byte 0 of a frame lives in the top bits of the word.
    function logic [FrameWidth-1:0] with_byte(input logic [FrameWidth-1:0] word,
                                              input logic [PosWidth-1:0] p,
                                              input logic [ByteWidth-1:0] b);
      int sh;
      sh = (FrameBytes - 1 - int'(p)) * ByteWidth;
      word[sh +: ByteWidth] = b;
      return word;
    endfunction

    function void emit(input bit last);
      itp_frame_t f;
      f.id   = held_id;
      f.data = frame_word;
      f.last = last;
      frames_due.push_back(f);
    endfunction

    // Apply one accepted request to the predicted segmenter state.
    function void note_request(input logic [IdWidth-1:0] id,
                               input logic [LenWidth-1:0] len,
                               input logic [ByteWidth-1:0] b);
      bit done;
      requests++;
      if (!busy) begin
        held_id    = id;
        held_len   = len;
        taken      = '0;
        seq        = SeqStart;
        frame_word = {FrameBytes{pad}};
        // A zero-length message is a lone empty single frame.
        if (len == '0) begin
          frame_word = with_byte(frame_word, '0, '0);
          pos = '0;
          emit(1'b1);
          return;
        end
        busy = 1'b1;
        if (len < SingleLimit) begin
          frame_word = with_byte(frame_word, 3'd0, len[ByteWidth-1:0]);
          pos = 3'd1;
        end else begin
          frame_word = with_byte(frame_word, 3'd0, {PciFirstFrame, len[11:8]});
          frame_word = with_byte(frame_word, 3'd1, len[7:0]);
          pos = 3'd2;
        end
      end else if (pos == '0) begin
        // Open a consecutive frame with the padding in force right now.
        frame_word = {FrameBytes{pad}};
        frame_word = with_byte(frame_word, 3'd0, {PciConsecutive, seq});
        seq = seq + 4'd1;
        pos = 3'd1;
      end
      frame_word = with_byte(frame_word, pos, b);
      taken = taken + LenWidth'(1);
      done = (taken == held_len);
      if (pos >= PosLast || done) begin
        emit(done);
        pos = '0;
        if (done) begin
          busy = 1'b0;
        end
      end else begin
        pos = pos + 3'd1;
      end
    endfunction

    // Compare one accepted frame with the oldest owed frame.
    function void check_frame(input logic [IdWidth-1:0] id,
                              input logic [FrameWidth-1:0] data,
                              input logic last);
      itp_frame_t want;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: frame with none owed: id %h data %h last %b", $time, id, data, last);
        return;
      end
      want = frames_due.pop_front();
      checked++;
      case (want.data[FrameWidth-1 -: 4])
        PciFirstFrame: begin
          firsts++;
        end
        PciConsecutive: begin
          consecutives++;
        end
        default: begin
          singles++;
        end
      endcase
      if (id !== want.id) begin
        errors++;
        $display("%0t: frame_id mismatch: expected %h, actual %h", $time, want.id, id);
      end
      if (data !== want.data) begin
        errors++;
        $display("%0t: frame_data mismatch: expected %h, actual %h", $time, want.data, data);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_of_message mismatch: expected %b, actual %b",
                 $time, want.last, last);
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [IdWidth-1:0]      can_id_i;
  logic [LenWidth-1:0]     message_length_i;
  logic [ByteWidth-1:0]    data_byte_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [IdWidth-1:0]      frame_id_o;
  logic [FrameWidth-1:0]   frame_data_o;
  logic                    last_of_message_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  frame_board  board;
  bit          gaps_on;
  bit          stall_on;
  bit          hold_off;
  int unsigned cycles;
  int unsigned pad_writes;

  isotp_transmit_segmenter DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .can_id_i          (can_id_i),
    .message_length_i  (message_length_i),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_id_o        (frame_id_o),
    .frame_data_o      (frame_data_o),
    .last_of_message_o (last_of_message_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Frame receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (stall_on && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Check every frame taken off the output channel.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_frame(frame_id_o, frame_data_o, last_of_message_o);
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic push_request(input logic [IdWidth-1:0] id,
                              input logic [LenWidth-1:0] len,
                              input logic [ByteWidth-1:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    can_id_i         <= id;
    message_length_i <= len;
    data_byte_i      <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(id, len, b);
  endtask

  // Send n payload bytes; only a starting request carries meaningful id and length.
  task automatic send_bytes(input logic [IdWidth-1:0] id, input logic [LenWidth-1:0] len,
                            input int unsigned n, input bit starting);
    for (int unsigned k = 0; k < n; k++) begin
      if (k == 0 && starting) begin
        push_request(id, len, ByteWidth'($urandom));
      end else begin
        push_request(IdWidth'($urandom), LenWidth'($urandom), ByteWidth'($urandom));
      end
    end
  endtask

  // Wait until every owed frame has arrived and the pipeline has emptied.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the padding register, then read it back.
  task automatic write_padding(input logic [ByteWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegPadding, 2'b00};
    pwdata  <= ApbDataWidth'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_padding(value);
    pad_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[ByteWidth-1:0] !== value) begin
      board.errors++;
      $display("%0t: padding readback mismatch: expected %h, actual %h",
               $time, value, prdata[ByteWidth-1:0]);
    end
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [LenWidth-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return '0;
    end else if (r < 55) begin
      return LenWidth'($urandom_range(1, 7));
    end else if (r < 85) begin
      return LenWidth'($urandom_range(8, 40));
    end
    return LenWidth'($urandom_range(41, 130));
  endfunction

  function automatic logic [IdWidth-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return IdWidth'($urandom);
  endfunction

  // Main sequence.
  initial begin
    logic [LenWidth-1:0]  len;
    logic [ByteWidth-1:0] pad;
    int unsigned          items;

    board            = new();
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    can_id_i         <= '0;
    message_length_i <= '0;
    data_byte_i      <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    gaps_on          = 1'b1;
    stall_on         = 1'b1;
    hold_off         = 1'b0;
    pad_writes       = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty messages, length extremes of a single frame, first frame.
    send_bytes('0, '0, 1, 1'b1);
    send_bytes('1, '0, 1, 1'b1);
    send_bytes('1, 12'd1, 1, 1'b1);
    send_bytes(11'h555, 12'd7, 7, 1'b1);
    // Padding changes between frames of one message: the next frame takes it.
    send_bytes(11'h2AA, 12'd8, 6, 1'b1);
    settle();
    write_padding(8'h00);
    send_bytes('0, '0, 2, 1'b0);
    // Padding change inside an open frame: the frame keeps its old padding.
    send_bytes(11'h123, 12'd5, 2, 1'b1);
    settle();
    write_padding(8'hFF);
    send_bytes('0, '0, 3, 1'b0);

    // Random phases, each under its own padding value.
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      if (phase == 1) begin
        pad = 8'hFF;
      end else if (phase == 3) begin
        pad = 8'h00;
      end else begin
        pad = ByteWidth'($urandom);
      end
      write_padding(pad);
      gaps_on  = (phase < 4);
      stall_on = (phase < 4);
      // A message above 255 bytes: high length bits and two sequence wraps.
      if (phase == 1) begin
        send_bytes(pick_id(), 12'd260, 260, 1'b1);
      end
      // The receiver holds off while a long message keeps arriving.
      if (phase == 2) begin
        hold_off = 1'b1;
        gaps_on  = 1'b0;
        send_bytes(pick_id(), 12'd40, 40, 1'b1);
        gaps_on  = 1'b1;
      end
      items = 0;
      while (items < 8) begin
        len = pick_length();
        send_bytes(pick_id(), len, (len == '0) ? 1 : int'(len), 1'b1);
        items += (len == '0) ? 1 : int'(len);
      end
    end

    settle();
    $display("Sent %0d requests under %0d padding settings; checked %0d frames.",
             board.requests, pad_writes + 1, board.checked);
    $display("Frames: %0d single, %0d first, %0d consecutive.",
             board.singles, board.firsts, board.consecutives);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
